@@ rtl/mss_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mss_pkg;

    // Motors asked for, and motors the state memory really holds.
    localparam int MOTORS_WANTED = 4;
    localparam int HW_MOTORS     = 4;
    localparam int MOTOR_ACTIVE  = (MOTORS_WANTED > HW_MOTORS) ? HW_MOTORS : MOTORS_WANTED;
    localparam int MOTOR_W       = 2;
    localparam logic [MOTOR_W-1:0] LAST_MOTOR = MOTOR_W'(MOTOR_ACTIVE - 1);

    localparam int DATA_W    = 16;
    localparam int CFG_IDX_W = 3;

    // Register indexes: delays first, then steps per revolution.
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_BASE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REV_BASE   = 3'd4;

    localparam logic [DATA_W-1:0] DELAY_RESET   = 16'd1;
    localparam logic [DATA_W-1:0] REV_RESET     = 16'd200;
    localparam logic [DATA_W-1:0] ELAPSED_MAX   = 16'hFFFF;

    // Input action codes.
    localparam logic ACT_MOVE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef struct packed {
        logic                     action;
        logic [MOTOR_W-1:0]       motor_index;
        logic signed [DATA_W-1:0] step_request;
    } t_in_item;

    typedef struct packed {
        logic [MOTOR_W-1:0] stepped_motor;
        logic [3:0]         coil_pattern;
        logic [DATA_W-1:0]  position;
        logic [DATA_W-1:0]  remaining;
    } t_result;

    typedef struct packed {
        logic [MOTOR_W-1:0] stepped_motor;
        logic [3:0]         coil_pattern;
        logic [DATA_W-1:0]  position;
        logic [DATA_W-1:0]  remaining;
        logic               last_of_tick;
    } t_out_item;

    // One motor's record in the state memory.
    typedef struct packed {
        logic [DATA_W-1:0] position;
        logic [DATA_W-1:0] remaining;
        logic              forward;
        logic [DATA_W-1:0] elapsed;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [DATA_W-1:0] delay;
        logic [DATA_W-1:0] rev_steps;
    } t_motor_cfg;

    typedef struct packed {
        logic   wr_en;
        logic   stepped;
        t_entry entry;
    } t_step_res;

    typedef struct packed {
        logic push;
        logic flush;
    } t_out_req;

    // Full-step coil drive for the low two bits of the position.
    function automatic logic [3:0] coil_of(input logic [1:0] phase);
        logic [3:0] pat;
        case (phase)
            2'd0:    pat = 4'h5;
            2'd1:    pat = 4'h6;
            2'd2:    pat = 4'hA;
            default: pat = 4'h9;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

@@ rtl/mss_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/mss_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mss_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [mss_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [mss_pkg::DATA_W-1:0]       i_cfg_wdata,
    input  wire logic [mss_pkg::MOTOR_W-1:0]      i_motor,
    output mss_pkg::t_motor_cfg                   o_cfg
);
    import mss_pkg::*;

    logic [DATA_W-1:0] r_delay [HW_MOTORS];
    logic [DATA_W-1:0] r_rev   [HW_MOTORS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < HW_MOTORS; m++) begin
                r_delay[m] <= DELAY_RESET;
                r_rev[m]   <= REV_RESET;
            end
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index < CFG_REV_BASE) begin
                r_delay[i_cfg_index[MOTOR_W-1:0]] <= i_cfg_wdata;
            end else begin
                r_rev[i_cfg_index[MOTOR_W-1:0]] <= i_cfg_wdata;
            end
        end
    end

    assign o_cfg.delay     = r_delay[i_motor];
    assign o_cfg.rev_steps = r_rev[i_motor];

endmodule

`default_nettype wire

@@ rtl/mss_step.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mss_step (
    input  wire logic                               i_action,
    input  wire logic [mss_pkg::MOTOR_W-1:0]        i_motor,
    input  wire logic signed [mss_pkg::DATA_W-1:0]  i_request,
    input  wire logic                               i_entry_valid,
    input  wire mss_pkg::t_entry                    i_entry,
    input  wire mss_pkg::t_motor_cfg                i_cfg,
    output mss_pkg::t_step_res                      o_res,
    output mss_pkg::t_result                        o_result
);
    import mss_pkg::*;

    logic [DATA_W-1:0] delay_eff;
    logic [DATA_W-1:0] wrap;
    logic [DATA_W-1:0] elapsed_inc;
    logic [DATA_W:0]   pos_up;
    t_entry            cur;
    t_entry            nxt;

    always_comb begin
        delay_eff   = (i_cfg.delay == '0) ? DATA_W'(1) : i_cfg.delay;
        wrap        = (i_cfg.rev_steps == '0) ? DATA_W'(1) : i_cfg.rev_steps;
        // An entry never written reads as zero through its valid bit.
        cur         = i_entry_valid ? i_entry : '0;
        nxt         = cur;
        elapsed_inc = (cur.elapsed == ELAPSED_MAX) ? cur.elapsed : cur.elapsed + DATA_W'(1);
        pos_up      = {1'b0, cur.position} + (DATA_W+1)'(1);
        o_res.wr_en   = 1'b0;
        o_res.stepped = 1'b0;

        if (i_action == ACT_MOVE) begin
            o_res.wr_en = 1'b1;
            if (i_request[DATA_W-1]) begin
                nxt.remaining = unsigned'(~i_request) + DATA_W'(1);
                nxt.forward   = 1'b0;
            end else begin
                nxt.remaining = unsigned'(i_request);
                if (i_request != '0) begin
                    nxt.forward = 1'b1;
                end
            end
        end else if (cur.remaining != '0) begin
            o_res.wr_en = 1'b1;
            if (elapsed_inc < delay_eff) begin
                nxt.elapsed = elapsed_inc;
            end else begin
                o_res.stepped = 1'b1;
                nxt.elapsed   = '0;
                nxt.remaining = cur.remaining - DATA_W'(1);
                if (cur.forward) begin
                    nxt.position = (pos_up >= {1'b0, wrap}) ? '0 : pos_up[DATA_W-1:0];
                end else begin
                    nxt.position = (cur.position == '0) ? wrap - DATA_W'(1)
                                                        : cur.position - DATA_W'(1);
                end
            end
        end

        o_res.entry            = nxt;
        o_result.stepped_motor = i_motor;
        o_result.coil_pattern  = coil_of(nxt.position[1:0]);
        o_result.position      = nxt.position;
        o_result.remaining     = nxt.remaining;
    end

endmodule

`default_nettype wire

@@ rtl/mss_out.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mss_out (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire mss_pkg::t_out_req i_req,
    input  wire mss_pkg::t_result  i_result,
    output logic                  o_ack,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output mss_pkg::t_out_item    o_out_item
);
    import mss_pkg::*;

    // A result is held back one place until it is known whether another
    // result of the same tick follows it.
    logic      r_pend_valid;
    t_result   r_pend;
    logic      r_out_valid;
    t_out_item r_out;
    logic      out_free;
    logic      move_out;

    assign out_free = !r_out_valid || i_out_ready;
    assign move_out = r_pend_valid && out_free && (i_req.push || i_req.flush);
    assign o_ack    = (i_req.push || i_req.flush) && (!r_pend_valid || out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (move_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_req.push && o_ack) begin
                r_pend_valid <= 1'b1;
            end else if (move_out) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move_out) begin
            r_out.stepped_motor <= r_pend.stepped_motor;
            r_out.coil_pattern  <= r_pend.coil_pattern;
            r_out.position      <= r_pend.position;
            r_out.remaining     <= r_pend.remaining;
            r_out.last_of_tick  <= i_req.flush;
        end
        if (i_req.push && o_ack) begin
            r_pend <= i_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

@@ rtl/multi_stepper_step_sequencer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Step sequencer for four stepper motors.
// The input channel (i_in_valid / o_in_ready / i_in_item) carries two kinds of
// transaction: a move, which loads one motor's remaining step count and
// direction and produces nothing, and a millisecond tick, which advances
// every busy motor and produces one output transaction for each motor that
// steps, lowest motor first, the final one flagged with last_of_tick.
// Motor state lives in a four-entry memory with a registered read; each motor
// is read in state S_READ, then updated and written back in S_EXEC.
// A move passes from acceptance through S_READ and S_EXEC back to idle; a
// tick reads and updates each motor in turn and then passes through S_FLUSH,
// and is stretched whenever the output is blocked.
// The block works on one input transaction at a time.
// Results pass through a one-deep holding stage and an output register.
// When the receiver holds i_out_ready low, results back up into the holding
// stage and the sweep pauses on the motor that needs to push; nothing is lost.
// Configuration (i_cfg_wr_en, i_cfg_index, i_cfg_wdata) takes effect at once
// and is meant to be written while the block is idle.
// Synchronous reset (i_rst_n low) sets delays to 1, steps per revolution to
// 200, and all motor records to zero through per-entry valid bits, so the
// block is ready as soon as reset is released.

module multi_stepper_step_sequencer_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire mss_pkg::t_in_item             i_in_item,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output mss_pkg::t_out_item                 o_out_item,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [mss_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [mss_pkg::DATA_W-1:0]    i_cfg_wdata
);
    import mss_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0]               r_state;
    logic [1:0]               n_state;
    logic                     r_action;
    logic [MOTOR_W-1:0]       r_idx;
    logic [MOTOR_W-1:0]       n_idx;
    logic signed [DATA_W-1:0] r_req;
    logic [HW_MOTORS-1:0]     r_valid;

    logic         ram_we;
    logic         ram_re;
    t_entry       ram_rdata;
    t_motor_cfg   motor_cfg;
    t_step_res    step_res;
    t_result      step_result;
    t_out_req     out_req;
    logic         out_ack;
    logic         motor_live;
    logic         accept;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    // A move to a motor that does not exist is dropped.
    assign motor_live = int'(r_idx) < MOTOR_ACTIVE;

    mss_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_motor     (r_idx),
        .o_cfg       (motor_cfg)
    );

    mss_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (HW_MOTORS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (step_res.entry),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    mss_step u_step (
        .i_action      (r_action),
        .i_motor       (r_idx),
        .i_request     (r_req),
        .i_entry_valid (r_valid[r_idx]),
        .i_entry       (ram_rdata),
        .i_cfg         (motor_cfg),
        .o_res         (step_res),
        .o_result      (step_result)
    );

    mss_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (out_req),
        .i_result    (step_result),
        .o_ack       (out_ack),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // Sequencer: read a motor's record, then update it and write it back.
    // The read data register holds while the update waits on the output,
    // since no new read is issued meanwhile.
    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        ram_re        = 1'b0;
        ram_we        = 1'b0;
        out_req.push  = 1'b0;
        out_req.flush = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_READ;
                    n_idx   = (i_in_item.action == ACT_MOVE) ? i_in_item.motor_index : '0;
                end
            end
            S_READ: begin
                ram_re  = 1'b1;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (r_action == ACT_MOVE) begin
                    ram_we  = step_res.wr_en && motor_live;
                    n_state = S_IDLE;
                end else begin
                    out_req.push = step_res.stepped;
                    if (!step_res.stepped || out_ack) begin
                        ram_we = step_res.wr_en;
                        if (r_idx == LAST_MOTOR) begin
                            n_state = S_FLUSH;
                        end else begin
                            n_idx   = r_idx + MOTOR_W'(1);
                            n_state = S_READ;
                        end
                    end
                end
            end
            S_FLUSH: begin
                out_req.flush = 1'b1;
                if (out_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (ram_we) begin
                r_valid[r_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_in_item.action;
            r_req    <= i_in_item.step_request;
        end
    end

endmodule

`default_nettype wire

@@ rtl/mss_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mss_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          o_in_ready,
    input  wire mss_pkg::t_in_item             i_in_item,
    input  wire logic                          o_out_valid,
    input  wire logic                          i_out_ready,
    input  wire mss_pkg::t_out_item            o_out_item,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [mss_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [mss_pkg::DATA_W-1:0]    i_cfg_wdata
);
    import mss_pkg::*;

    // A stalled result keeps its place and its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("output transaction dropped or changed while stalled");

    // The coil drive always matches the reported position.
    a_coil_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.coil_pattern == coil_of(o_out_item.position[1:0]))
        else $error("coil pattern does not follow position");

    // A move never gives rise to a new result: the previous tick is fully
    // drained into the output register before the next transaction is taken.
    a_move_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_item.action == ACT_MOVE |=> !$rose(o_out_valid))
        else $error("result appeared after a move");

    // Reset empties the output.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid straight after reset");

endmodule

bind multi_stepper_step_sequencer_core mss_checker u_mss_checker (.*);

`default_nettype wire

@@ test/mss_step_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels and the register port of the step sequencer. It keeps
// its own copy of every motor's record and the motor registers, works out the
// step results of each accepted input transaction and checks the results the
// block delivers, in order.
module mss_step_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_in_ready,
    input  mss_pkg::t_in_item                  i_in_item,
    input  wire logic                          i_out_valid,
    input  wire logic                          i_out_ready,
    input  mss_pkg::t_out_item                 i_out_item,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [mss_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [mss_pkg::DATA_W-1:0]    i_cfg_wdata,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_checked
);
    import mss_pkg::*;

    localparam int REPORT_LIMIT = 10;
    localparam logic [3:0] COIL_SEQ [4] = '{4'h5, 4'h6, 4'hA, 4'h9};

    logic [DATA_W-1:0] delay_cfg   [HW_MOTORS];
    logic [DATA_W-1:0] rev_cfg     [HW_MOTORS];
    logic [DATA_W-1:0] pos_now     [HW_MOTORS];
    logic [DATA_W-1:0] todo_steps  [HW_MOTORS];
    logic              heading_fwd [HW_MOTORS];
    logic [DATA_W-1:0] ms_elapsed  [HW_MOTORS];

    t_out_item step_expect_q [$];

    int fail_total    = 0;
    int checked_total = 0;
    int pending_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;
    assign o_checked    = checked_total;

    task automatic note_failure(input string what, input t_out_item exp, input t_out_item got);
        fail_total++;
        if (fail_total <= REPORT_LIMIT) begin
            $display("%0t: %s: expected motor=%0d coil=%h pos=%0d left=%0d last=%0b,",
                     $time, what, exp.stepped_motor, exp.coil_pattern, exp.position,
                     exp.remaining, exp.last_of_tick);
            $display("    got motor=%0d coil=%h pos=%0d left=%0d last=%0b",
                     got.stepped_motor, got.coil_pattern, got.position, got.remaining,
                     got.last_of_tick);
        end
    endtask

    // Applies one move or one tick to the motor records and queues the step
    // results that a tick causes, lowest motor first.
    task automatic predict_steps(input t_in_item it);
        int        idx;
        int        m;
        int        n;
        int        lim;
        int        wrap;
        int        p;
        logic [16:0] mag;
        t_out_item batch [HW_MOTORS];
        if (it.action == ACT_MOVE) begin
            idx = int'(it.motor_index);
            if (idx < MOTOR_ACTIVE) begin
                if (it.step_request[DATA_W-1]) begin
                    mag = 17'h10000 - {1'b0, it.step_request};
                    heading_fwd[idx] = 1'b0;
                end else begin
                    mag = {1'b0, it.step_request};
                    if (it.step_request != '0)
                        heading_fwd[idx] = 1'b1;
                end
                todo_steps[idx] = mag[DATA_W-1:0];
            end
        end else begin
            n = 0;
            for (m = 0; m < MOTOR_ACTIVE; m++) begin
                if (todo_steps[m] != '0) begin
                    if (ms_elapsed[m] != ELAPSED_MAX)
                        ms_elapsed[m] = ms_elapsed[m] + 1'b1;
                    lim = (delay_cfg[m] == '0) ? 1 : int'(delay_cfg[m]);
                    if (int'(ms_elapsed[m]) >= lim) begin
                        ms_elapsed[m] = '0;
                        wrap = (rev_cfg[m] == '0) ? 1 : int'(rev_cfg[m]);
                        p = int'(pos_now[m]);
                        if (heading_fwd[m])
                            p = (p + 1 >= wrap) ? 0 : p + 1;
                        else
                            p = (p == 0) ? wrap - 1 : p - 1;
                        pos_now[m]    = DATA_W'(p);
                        todo_steps[m] = todo_steps[m] - 1'b1;
                        batch[n].stepped_motor = MOTOR_W'(m);
                        batch[n].coil_pattern  = COIL_SEQ[pos_now[m][1:0]];
                        batch[n].position      = pos_now[m];
                        batch[n].remaining     = todo_steps[m];
                        batch[n].last_of_tick  = 1'b0;
                        n++;
                    end
                end
            end
            if (n > 0)
                batch[n-1].last_of_tick = 1'b1;
            for (m = 0; m < n; m++)
                step_expect_q.push_back(batch[m]);
        end
    endtask

    always @(posedge i_clk) begin : watch
        int        ri;
        int        m;
        t_out_item exp;
        if (!i_rst_n) begin
            for (m = 0; m < HW_MOTORS; m++) begin
                delay_cfg[m]   = DELAY_RESET;
                rev_cfg[m]     = REV_RESET;
                pos_now[m]     = '0;
                todo_steps[m]  = '0;
                heading_fwd[m] = 1'b0;
                ms_elapsed[m]  = '0;
            end
            step_expect_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (step_expect_q.size() == 0) begin
                    note_failure("step result with nothing expected", '0, i_out_item);
                end else begin
                    exp = step_expect_q.pop_front();
                    checked_total++;
                    if (exp.stepped_motor !== i_out_item.stepped_motor ||
                        exp.coil_pattern  !== i_out_item.coil_pattern  ||
                        exp.position      !== i_out_item.position      ||
                        exp.remaining     !== i_out_item.remaining     ||
                        exp.last_of_tick  !== i_out_item.last_of_tick)
                        note_failure("step result mismatch", exp, i_out_item);
                end
            end
            if (i_cfg_wr_en) begin
                ri = int'(i_cfg_index);
                if (ri < int'(CFG_REV_BASE))
                    delay_cfg[ri - int'(CFG_DELAY_BASE)] = i_cfg_wdata;
                else if (ri < int'(CFG_REV_BASE) + HW_MOTORS)
                    rev_cfg[ri - int'(CFG_REV_BASE)] = i_cfg_wdata;
            end
            if (i_in_valid && i_in_ready)
                predict_steps(i_in_item);
        end
        pending_total = step_expect_q.size();
    end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

// Regression bench for the four-motor step sequencer. This module only makes
// stimulus and gives the verdict; the checker instance beside the block does
// all prediction and comparison.
module tb_top;
    import mss_pkg::*;

    // The slowest correct run is well under a tenth of this, even when every
    // item waits out the longest input gap and each result of a tick sits out
    // the longest receiver stall.
    localparam int CYCLE_LIMIT   = 400000;
    // A tick that steps no motor still keeps the block busy through its sweep and flush.
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 14;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_in_item             i_in_item   = '0;
    logic                 i_out_ready = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DATA_W-1:0]    i_cfg_wdata = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    t_out_item            o_out_item;

    int fail_count;
    int pending;
    int checked;
    int cycle_count    = 0;
    int sent           = 0;
    int settings_count = 0;
    int stall_left     = 0;
    // While calm is set neither side idles, so transactions run back to back.
    bit calm           = 1'b0;

    logic [DATA_W-1:0] delay_set [HW_MOTORS];
    logic [DATA_W-1:0] rev_set   [HW_MOTORS];

    multi_stepper_step_sequencer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    mss_step_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_item   (o_out_item),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #4 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Watchdog expired after %0d cycles with %0d results outstanding.",
                     cycle_count, pending);
            $display("multi_stepper_step_sequencer_core regression: fail");
            $finish;
        end
    end

    // Receiver side. Random stalls of varied length make results back up into
    // the block's holding stage at every point of a tick's sweep.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 15)
                stall_left = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3)
                                                          : $urandom_range(8, 40);
        end
    end

    // Idle cycles ahead of the next input transaction.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Signed step request: mostly short moves either way, with the extremes
    // and arbitrary 16-bit values mixed in.
    function automatic logic [DATA_W-1:0] pick_request();
        int r;
        int mag;
        r   = $urandom_range(0, 99);
        mag = $urandom_range(1, 12);
        if (r < 55)
            return ($urandom_range(0, 1) != 0) ? DATA_W'(mag) : DATA_W'(-mag);
        if (r < 65)
            return '0;
        if (r < 72)
            return 16'h8000;
        if (r < 78)
            return 16'h7FFF;
        return DATA_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [DATA_W-1:0] pick_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return DATA_W'($urandom_range(1, 4));
        if (r < 75)
            return DATA_W'($urandom_range(5, 9));
        if (r < 85)
            return '0;
        if (r < 92)
            return 16'hFFFF;
        return DATA_W'($urandom_range(1, 65535));
    endfunction

    function automatic logic [DATA_W-1:0] pick_rev();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return DATA_W'($urandom_range(1, 8));
        if (r < 55)
            return REV_RESET;
        if (r < 65)
            return '0;
        if (r < 75)
            return 16'hFFFF;
        if (r < 85)
            return 16'd1;
        return DATA_W'($urandom_range(1, 65535));
    endfunction

    function automatic t_in_item make_move(input int m, input logic [DATA_W-1:0] req);
        t_in_item it;
        it.action       = ACT_MOVE;
        it.motor_index  = MOTOR_W'(m);
        it.step_request = req;
        return it;
    endfunction

    // A tick ignores the other two fields, so they are filled with noise.
    function automatic t_in_item make_tick();
        t_in_item it;
        it.action       = ACT_TICK;
        it.motor_index  = MOTOR_W'($urandom_range(0, 3));
        it.step_request = DATA_W'($urandom_range(0, 65535));
        return it;
    endfunction

    // Offers one transaction and returns just after the edge that takes it.
    // Valid is left high on return; the next call either lowers it for a gap
    // or simply replaces the payload, never both in the same time step.
    task automatic send_item(input t_in_item it);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        sent++;
    endtask

    task automatic write_reg(input int idx, input logic [DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_IDX_W'(idx);
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Writes all eight motor registers from delay_set and rev_set.
    task automatic apply_settings();
        int m;
        for (m = 0; m < HW_MOTORS; m++) begin
            write_reg(int'(CFG_DELAY_BASE) + m, delay_set[m]);
            write_reg(int'(CFG_REV_BASE) + m, rev_set[m]);
        end
        settings_count++;
    endtask

    // Brings the block to idle: input withdrawn, every expected result in,
    // then a settle wait for a tick that steps nothing or a move.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int       p;
        int       n;
        int       k;
        int       m;
        t_in_item it;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, first setting: mixed delays including zero, and
        // wrap values of one and zero, so some positions must stay at zero.
        delay_set = '{16'd1, 16'd2, 16'd3, 16'd0};
        rev_set   = '{16'd200, 16'd1, 16'd3, 16'd0};
        apply_settings();
        // A tick with every motor idle gives nothing.
        send_item(make_tick());
        send_item(make_move(0, 16'd5));
        send_item(make_move(1, 16'd4));
        send_item(make_move(2, -16'sd6));
        // The most negative request loads a count of 32768, going backward.
        send_item(make_move(3, 16'h8000));
        repeat (3) send_item(make_tick());
        // A zero request stops a motor and keeps its direction; a new move
        // in mid-motion keeps the time already counted.
        send_item(make_move(1, 16'd0));
        send_item(make_move(2, 16'd2));
        send_item(make_move(0, 16'h7FFF));
        repeat (2) send_item(make_tick());
        send_item(make_move(0, 16'd0));
        send_item(make_move(3, 16'd0));
        send_item(make_tick());
        drain();

        // Extremes: the longest delay and the widest wrap, so a backward step
        // from zero lands on the highest position.
        delay_set = '{16'hFFFF, 16'd1, 16'd1, 16'd1};
        rev_set   = '{16'hFFFF, 16'd2, 16'hFFFF, 16'd5};
        apply_settings();
        send_item(make_move(0, 16'd1));
        send_item(make_move(2, -16'sd3));
        send_item(make_move(1, -16'sd5));
        send_item(make_move(3, 16'd7));
        repeat (3) send_item(make_tick());
        drain();

        // Narrow the wrap below positions already reached: a forward step
        // from there must come back to zero.
        delay_set = '{16'd1, 16'd1, 16'd1, 16'd1};
        rev_set   = '{16'd4, 16'd3, 16'd4, 16'd3};
        apply_settings();
        send_item(make_move(2, 16'd2));
        repeat (2) send_item(make_tick());

        // Random part. Most of it is a move followed by a few ticks, so that
        // motors really step; the rest is free-form transactions.
        for (p = 0; p < RANDOM_PHASES; p++) begin
            drain();
            for (m = 0; m < HW_MOTORS; m++) begin
                delay_set[m] = pick_delay();
                rev_set[m]   = pick_rev();
            end
            calm = (p == 2);
            apply_settings();
            n = 0;
            while (n < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) < 7) begin
                    send_item(make_move($urandom_range(0, 3), pick_request()));
                    k = $urandom_range(1, 4);
                    repeat (k) send_item(make_tick());
                    n += 1 + k;
                end else begin
                    it.action       = 1'($urandom_range(0, 1));
                    it.motor_index  = MOTOR_W'($urandom_range(0, 3));
                    it.step_request = DATA_W'($urandom_range(0, 65535));
                    send_item(it);
                    n++;
                end
            end
        end
        calm = 1'b0;
        drain();

        $display("Covered %0d input transactions under %0d register settings;",
                 sent, settings_count);
        $display("%0d step results checked, with moves of every size and sign, ticks,",
                 checked);
        $display("stalls and gaps on both channels.");
        if (fail_count == 0 && pending == 0) begin
            $display("multi_stepper_step_sequencer_core regression: pass");
        end else begin
            $display("%0d failures, %0d results never arrived.", fail_count, pending);
            $display("multi_stepper_step_sequencer_core regression: fail");
        end
        $finish;
    end

endmodule
